// File: hdl/fvgc_pkg.sv
package fvgc_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int NORMAL_WIDTH    = 16;
    localparam int OFFSET_WIDTH    = 16;
    localparam int Q_SHIFT         = 14;
    localparam int PROD_WIDTH      = NORMAL_WIDTH + COORD_WIDTH;
    localparam int DIST_WIDTH      = 36;
    localparam int NUM_PLANES      = 6;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 64;

    localparam logic [NUM_PLANES-1:0] ALL_PLANES = {NUM_PLANES{1'b1}};

    localparam logic [CFG_INDEX_WIDTH-1:0] PLANE_FRONT  = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] PLANE_BACK   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] PLANE_TOP    = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] PLANE_BOTTOM = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] PLANE_LEFT   = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] PLANE_RIGHT  = 3'd5;

    typedef struct packed {
        logic signed [OFFSET_WIDTH-1:0] d;
        logic signed [NORMAL_WIDTH-1:0] nz;
        logic signed [NORMAL_WIDTH-1:0] ny;
        logic signed [NORMAL_WIDTH-1:0] nx;
    } plane_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] vertex_x;
        logic signed [COORD_WIDTH-1:0] vertex_y;
        logic signed [COORD_WIDTH-1:0] vertex_z;
        logic                          last_vertex;
    } vertex_t;

    typedef struct packed {
        logic                  visible;
        logic [NUM_PLANES-1:0] outside_mask;
    } result_t;

endpackage

// File: hdl/frustum_vertex_group_cull.sv
// Six-plane view-frustum cull of vertex groups.
// Vertices enter on the vertex channel (vertex_valid, vertex_stall, vertex), one
// request per cycle while vertex_stall is low; a group ends at the vertex whose
// last_vertex bit is set. One result request leaves on the result channel for each
// group: the mask of planes that every vertex lies strictly behind, and visible when
// that mask is clear. An accepted vertex is held in the input register while the six
// plane distances are formed in parallel; the result register is loaded as the last
// vertex of a group leaves the input register, and the result is offered from there.
// Throughput is one vertex per cycle while vertex_stall is low, set by the single
// pass of six parallel dot products between the input and result registers.
// While the result channel is stalled with a result waiting, vertices that are not
// the last of their group still flow; a last vertex waits in the input register
// and vertex_stall rises until the waiting result is taken.
// Planes are written through cfg_write, cfg_index and cfg_data; the user must write
// them only while the block is idle, as the block does not enforce it; indexes above
// five are ignored. Reset clears all planes to zero and empties both registers.
module frustum_vertex_group_cull (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 vertex_valid,
    output logic                                 vertex_stall,
    input  fvgc_pkg::vertex_t                    vertex,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output fvgc_pkg::result_t                    result,
    input  logic                                 cfg_write,
    input  logic [fvgc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [fvgc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    fvgc_pkg::plane_t [fvgc_pkg::NUM_PLANES-1:0] planes;

    logic                             item_valid_reg;
    logic                             item_valid_next;
    fvgc_pkg::vertex_t                item_reg;
    logic [fvgc_pkg::NUM_PLANES-1:0]  mask_reg;
    logic [fvgc_pkg::NUM_PLANES-1:0]  mask_next;
    logic                             result_valid_reg;
    logic                             result_valid_next;
    fvgc_pkg::result_t                result_reg;
    fvgc_pkg::result_t                result_next;

    logic [fvgc_pkg::NUM_PLANES-1:0]  behind;
    logic [fvgc_pkg::NUM_PLANES-1:0]  mask_narrow;
    logic                             out_free;
    logic                             item_advance;
    logic                             item_emit;

    fvgc_plane_regs u_plane_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .planes    (planes)
    );

    for (genvar i = 0; i < fvgc_pkg::NUM_PLANES; i++)
    begin : g_plane
        fvgc_plane_test u_plane_test (
            .plane  (planes[i]),
            .vertex (item_reg),
            .behind (behind[i])
        );
    end

    assign out_free     = !result_valid_reg || !result_stall;
    assign item_advance = item_valid_reg && (!item_reg.last_vertex || out_free);
    assign item_emit    = item_advance && item_reg.last_vertex;
    assign vertex_stall = item_valid_reg && !item_advance;
    assign mask_narrow  = mask_reg & behind;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (!vertex_stall)
        begin
            item_valid_next = vertex_valid;
        end

        mask_next = mask_reg;
        if (item_advance)
        begin
            mask_next = item_reg.last_vertex ? fvgc_pkg::ALL_PLANES : mask_narrow;
        end

        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (item_emit)
        begin
            result_valid_next        = 1'b1;
            result_next.visible      = (mask_narrow == '0);
            result_next.outside_mask = mask_narrow;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            mask_reg         <= fvgc_pkg::ALL_PLANES;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            mask_reg         <= mask_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vertex_valid && !vertex_stall)
        begin
            item_reg <= vertex;
        end
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: hdl/fvgc_plane_regs.sv
module fvgc_plane_regs (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cfg_write,
    input  logic [fvgc_pkg::CFG_INDEX_WIDTH-1:0]         cfg_index,
    input  logic [fvgc_pkg::CFG_DATA_WIDTH-1:0]          cfg_data,
    output fvgc_pkg::plane_t [fvgc_pkg::NUM_PLANES-1:0]  planes
);

    fvgc_pkg::plane_t [fvgc_pkg::NUM_PLANES-1:0] planes_reg;
    fvgc_pkg::plane_t [fvgc_pkg::NUM_PLANES-1:0] planes_next;

    always_comb
    begin
        planes_next = planes_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                fvgc_pkg::PLANE_FRONT:  planes_next[0] = cfg_data;
                fvgc_pkg::PLANE_BACK:   planes_next[1] = cfg_data;
                fvgc_pkg::PLANE_TOP:    planes_next[2] = cfg_data;
                fvgc_pkg::PLANE_BOTTOM: planes_next[3] = cfg_data;
                fvgc_pkg::PLANE_LEFT:   planes_next[4] = cfg_data;
                fvgc_pkg::PLANE_RIGHT:  planes_next[5] = cfg_data;
                default:                planes_next = planes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            planes_reg <= '0;
        end
        else
        begin
            planes_reg <= planes_next;
        end
    end

    assign planes = planes_reg;

endmodule

// File: hdl/fvgc_plane_test.sv
module fvgc_plane_test (
    input  fvgc_pkg::plane_t  plane,
    input  fvgc_pkg::vertex_t vertex,
    output logic              behind
);

    logic signed [fvgc_pkg::PROD_WIDTH-1:0] prod_x;
    logic signed [fvgc_pkg::PROD_WIDTH-1:0] prod_y;
    logic signed [fvgc_pkg::PROD_WIDTH-1:0] prod_z;
    logic signed [fvgc_pkg::DIST_WIDTH-1:0] offset;
    logic signed [fvgc_pkg::DIST_WIDTH-1:0] distance;

    assign prod_x = plane.nx * vertex.vertex_x;
    assign prod_y = plane.ny * vertex.vertex_y;
    assign prod_z = plane.nz * vertex.vertex_z;

    // The offset is held in coordinate units and is brought up to the Q1.14 scale of the products.
    assign offset = fvgc_pkg::DIST_WIDTH'(plane.d) <<< fvgc_pkg::Q_SHIFT;

    assign distance = fvgc_pkg::DIST_WIDTH'(prod_x) + fvgc_pkg::DIST_WIDTH'(prod_y)
                    + fvgc_pkg::DIST_WIDTH'(prod_z) + offset;

    assign behind = distance[fvgc_pkg::DIST_WIDTH-1];

endmodule

// File: test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int MAX_REPORTS    = 10;
    localparam int DRAIN_CYCLES   = 6;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int HOLDOFF_AFTER  = 700;
    localparam int FULL_SPREAD    = 65536;
    localparam int COORD_HI       = 32767;
    localparam int COORD_LO       = -32768;
    localparam int Q_ONE          = 1 << fvgc_pkg::Q_SHIFT;

    localparam logic [fvgc_pkg::CFG_INDEX_WIDTH-1:0] PLANE_SPARE_LO = 3'd6;
    localparam logic [fvgc_pkg::CFG_INDEX_WIDTH-1:0] PLANE_SPARE_HI = 3'd7;

    typedef enum {
        PLANES_FRUSTUM,
        PLANES_GENERAL,
        PLANES_RAW,
        PLANES_AXIS,
        PLANES_EXTREME
    } plane_kind_t;

    logic                                 clk          = 1'b0;
    logic                                 rst_n        = 1'b0;
    logic                                 vertex_valid = 1'b0;
    logic                                 vertex_stall;
    fvgc_pkg::vertex_t                    vertex       = '0;
    logic                                 result_valid;
    logic                                 result_stall = 1'b0;
    fvgc_pkg::result_t                    result;
    logic                                 cfg_write    = 1'b0;
    logic [fvgc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index    = '0;
    logic [fvgc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data     = '0;

    fvgc_pkg::vertex_t               pending_vertices[$];
    fvgc_pkg::result_t               expected_results[$];
    fvgc_pkg::plane_t                plane_set [fvgc_pkg::NUM_PLANES] = '{default: '0};
    logic [fvgc_pkg::NUM_PLANES-1:0] group_mask = fvgc_pkg::ALL_PLANES;

    int vertices_accepted = 0;
    int groups_checked    = 0;
    int groups_culled     = 0;
    int plane_settings    = 0;
    int failures          = 0;
    int cycle_count       = 0;
    int burst_left        = 0;
    int gap_left          = 0;
    int stall_mode        = 0;
    int mode_left         = 0;
    int holdoff_left      = 0;
    bit holdoff_done      = 1'b0;

    frustum_vertex_group_cull DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .vertex       (vertex),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [fvgc_pkg::CFG_DATA_WIDTH-1:0] make_plane(input int nx,
                                                                       input int ny,
                                                                       input int nz,
                                                                       input int d);
        fvgc_pkg::plane_t p;
        p.nx = 16'(nx);
        p.ny = 16'(ny);
        p.nz = 16'(nz);
        p.d  = 16'(d);
        return p;
    endfunction

    function automatic logic signed [fvgc_pkg::COORD_WIDTH-1:0] offset_coord(
        input int centre, input int unsigned spread);
        int t;
        if (spread >= FULL_SPREAD)
            return 16'($urandom);
        t = centre + int'($urandom_range(0, 2 * spread)) - int'(spread);
        if (t > COORD_HI)
            t = COORD_HI;
        if (t < COORD_LO)
            t = COORD_LO;
        return 16'(t);
    endfunction

    task automatic note_failure(input string text);
        if (failures < MAX_REPORTS)
            $display("%s", text);
        failures++;
    endtask

    task automatic set_plane(input logic [fvgc_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [fvgc_pkg::CFG_DATA_WIDTH-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx < fvgc_pkg::NUM_PLANES)
            plane_set[idx] = fvgc_pkg::plane_t'(value);
    endtask

    task automatic load_planes(input plane_kind_t kind);
        logic [fvgc_pkg::CFG_DATA_WIDTH-1:0] value;
        int                                  sign;
        for (int i = 0; i < fvgc_pkg::NUM_PLANES; i++)
        begin
            sign = ($urandom_range(0, 1) == 0) ? Q_ONE : -Q_ONE;
            case (kind)
                PLANES_FRUSTUM:
                    case (i)
                        fvgc_pkg::PLANE_FRONT:  value = make_plane(0, 0, Q_ONE, 0);
                        fvgc_pkg::PLANE_BACK:   value = make_plane(0, 0, -Q_ONE, 1000);
                        fvgc_pkg::PLANE_TOP:    value = make_plane(0, -Q_ONE, 0, 500);
                        fvgc_pkg::PLANE_BOTTOM: value = make_plane(0, Q_ONE, 0, 500);
                        fvgc_pkg::PLANE_LEFT:   value = make_plane(Q_ONE, 0, 0, 500);
                        default:                value = make_plane(-Q_ONE, 0, 0, 500);
                    endcase
                PLANES_GENERAL:
                    value = make_plane($urandom_range(0, 2 * Q_ONE) - Q_ONE,
                                       $urandom_range(0, 2 * Q_ONE) - Q_ONE,
                                       $urandom_range(0, 2 * Q_ONE) - Q_ONE,
                                       $urandom);
                PLANES_RAW:
                    value = {$urandom, $urandom};
                PLANES_AXIS:
                    case ($urandom_range(0, 2))
                        0:       value = make_plane(sign, 0, 0, $urandom_range(0, 128) - 64);
                        1:       value = make_plane(0, sign, 0, $urandom_range(0, 128) - 64);
                        default: value = make_plane(0, 0, sign, $urandom_range(0, 128) - 64);
                    endcase
                default:
                    case ($urandom_range(0, 4))
                        0:       value = '0;
                        1:       value = '1;
                        2:       value = {4{16'h8000}};
                        3:       value = {4{16'h7FFF}};
                        default: value = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
                    endcase
            endcase
            set_plane(i[fvgc_pkg::CFG_INDEX_WIDTH-1:0], value);
        end
        if (kind == PLANES_FRUSTUM || $urandom_range(0, 1) == 0)
        begin
            set_plane(PLANE_SPARE_LO, {$urandom, $urandom});
            set_plane(PLANE_SPARE_HI, {$urandom, $urandom});
        end
        cfg_write <= 1'b0;
        plane_settings++;
    endtask

    task automatic queue_vertex(input int x, input int y, input int z, input bit last);
        fvgc_pkg::vertex_t v;
        v.vertex_x    = 16'(x);
        v.vertex_y    = 16'(y);
        v.vertex_z    = 16'(z);
        v.last_vertex = last;
        pending_vertices.push_back(v);
    endtask

    task automatic queue_random(input int unsigned items, input bit centred);
        fvgc_pkg::vertex_t v;
        int unsigned       queued;
        int unsigned       count;
        int unsigned       spread;
        int                cx;
        int                cy;
        int                cz;
        queued = 0;
        while (queued < items)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: count = 1;
                3, 4, 5: count = 4;
                6, 7, 8: count = 8;
                default: count = $urandom_range(2, 12);
            endcase
            case ($urandom_range(0, 4))
                0:       spread = 0;
                1:       spread = $urandom_range(1, 64);
                2:       spread = $urandom_range(64, 4000);
                3:       spread = 20000;
                default: spread = FULL_SPREAD;
            endcase
            if (centred)
            begin
                spread = $urandom_range(0, 64);
                cx = 0;
                cy = 0;
                cz = 0;
            end
            else
            begin
                cx = int'(offset_coord(0, FULL_SPREAD));
                cy = int'(offset_coord(0, FULL_SPREAD));
                cz = int'(offset_coord(0, FULL_SPREAD));
            end
            for (int k = 0; k < count; k++)
            begin
                v.vertex_x    = offset_coord(cx, spread);
                v.vertex_y    = offset_coord(cy, spread);
                v.vertex_z    = offset_coord(cz, spread);
                v.last_vertex = (k == count - 1);
                pending_vertices.push_back(v);
            end
            queued += count;
        end
    endtask

    task automatic wait_idle();
        while (pending_vertices.size() != 0 || vertex_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Sender: vertex requests in bursts, each vertex folded into the expected mask on acceptance.
    always @(posedge clk)
    begin : drive_vertices
        logic [fvgc_pkg::NUM_PLANES-1:0] behind;
        longint                          distance;
        fvgc_pkg::result_t               r;
        if (rst_n)
        begin
            if (vertex_valid && !vertex_stall)
            begin
                for (int i = 0; i < fvgc_pkg::NUM_PLANES; i++)
                begin
                    distance = longint'($signed(plane_set[i].nx)) * longint'(vertex.vertex_x)
                             + longint'($signed(plane_set[i].ny)) * longint'(vertex.vertex_y)
                             + longint'($signed(plane_set[i].nz)) * longint'(vertex.vertex_z)
                             + (longint'($signed(plane_set[i].d)) <<< fvgc_pkg::Q_SHIFT);
                    behind[i] = (distance < 0);
                end
                group_mask &= behind;
                vertices_accepted++;
                if (vertex.last_vertex)
                begin
                    r.visible      = (group_mask == '0);
                    r.outside_mask = group_mask;
                    expected_results.push_back(r);
                    group_mask = fvgc_pkg::ALL_PLANES;
                end
            end
            if (!vertex_valid || !vertex_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    vertex_valid <= 1'b0;
                end
                else if (pending_vertices.size() != 0)
                begin
                    vertex       <= pending_vertices.pop_front();
                    vertex_valid <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    vertex_valid <= 1'b0;
            end
        end
    end

    // Receiver: a randomly chosen stall pattern, chosen anew when its mode count runs out, and one long hold-off.
    always @(posedge clk)
    begin
        if (holdoff_left != 0)
        begin
            holdoff_left--;
            result_stall <= 1'b1;
        end
        else if (!holdoff_done && vertices_accepted >= HOLDOFF_AFTER)
        begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
            result_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 96);
            end
            else
                mode_left--;
            case (stall_mode)
                0:       result_stall <= 1'b0;
                1:       result_stall <= ($urandom_range(0, 3) == 0);
                2:       result_stall <= ($urandom_range(0, 3) != 0);
                default: result_stall <= ~result_stall;
            endcase
        end
    end

    always @(posedge clk)
    begin : check_results
        fvgc_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
                note_failure($sformatf("unexpected result request: visible=%0b mask=%06b",
                                       result.visible, result.outside_mask));
            else
            begin
                want = expected_results.pop_front();
                groups_checked++;
                if (!want.visible)
                    groups_culled++;
                if (result.visible !== want.visible || result.outside_mask !== want.outside_mask)
                    note_failure($sformatf(
                        "group %0d: expected visible=%0b mask=%06b, got visible=%0b mask=%06b",
                        groups_checked, want.visible, want.outside_mask,
                        result.visible, result.outside_mask));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("frustum_vertex_group_cull: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        plane_kind_t order [6];
        order = '{PLANES_GENERAL, PLANES_RAW, PLANES_AXIS,
                  PLANES_EXTREME, PLANES_GENERAL, PLANES_EXTREME};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // With every plane still zero, nothing can be culled.
        queue_vertex(COORD_HI, COORD_HI, COORD_HI, 1'b1);
        queue_vertex(COORD_LO, COORD_LO, COORD_LO, 1'b0);
        queue_vertex(COORD_HI, COORD_LO, 0, 1'b0);
        queue_vertex(0, COORD_HI, COORD_LO, 1'b0);
        queue_vertex(-1, -1, -1, 1'b1);
        wait_idle();

        load_planes(PLANES_FRUSTUM);
        queue_vertex(0, 0, 500, 1'b1);
        queue_vertex(0, 0, -1, 1'b1);
        queue_vertex(0, 0, 0, 1'b1);
        queue_vertex(501, 501, 2000, 1'b1);
        queue_vertex(COORD_LO, COORD_LO, COORD_LO, 1'b1);
        queue_vertex(COORD_HI, COORD_HI, COORD_HI, 1'b1);
        // A vertex lying exactly on the near plane keeps the quad visible.
        queue_vertex(0, 0, -5, 1'b0);
        queue_vertex(10, 0, -5, 1'b0);
        queue_vertex(0, 10, -1, 1'b0);
        queue_vertex(0, 0, 0, 1'b1);
        for (int k = 0; k < 8; k++)
            queue_vertex(600 + (k & 1) * 100, (k & 2) * 50 - 100, (k & 4) * 300 - 200, k == 7);
        wait_idle();

        foreach (order[p])
        begin
            load_planes(order[p]);
            queue_random((p == 4) ? 280 : 255, order[p] == PLANES_AXIS);
            wait_idle();
        end

        $display("Checked %0d cull results from %0d vertices under %0d plane settings.",
                 groups_checked, vertices_accepted, plane_settings);
        $display("%0d groups were culled by at least one plane; %0d checks failed.",
                 groups_culled, failures);
        if (failures == 0)
            $display("frustum_vertex_group_cull: match");
        else
            $display("frustum_vertex_group_cull: mismatch");
        $finish;
    end
endmodule
